// File: rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define LSI_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LSI_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/lsi_pkg.sv
// Shared constants for the line / sphere intersection core.
package lsi_pkg;

   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int MUL_CHUNK = 16;
   localparam int EPS_WIDTH = 32;
   localparam logic [EPS_WIDTH-1:0] EPS_RESET = 32'd1;

   localparam logic [1:0] HITS_NONE    = 2'd0;
   localparam logic [1:0] HITS_TANGENT = 2'd1;
   localparam logic [1:0] HITS_CROSS   = 2'd2;

endpackage

// File: rtl/core/lsi_delay.sv
// Register line that carries a word and its valid bit alongside an arithmetic unit.
module lsi_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data
);

   logic             vld_ff  [DEPTH];
   logic [WIDTH-1:0] data_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k < DEPTH; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff[0] <= in_data;
         for (int k = 1; k < DEPTH; k++) data_ff[k] <= data_ff[k-1];
      end
   end

   assign out_valid = vld_ff[DEPTH-1];
   assign out_data  = data_ff[DEPTH-1];

endmodule

// File: rtl/core/lsi_mul.sv
// Pipelined signed multiplier, one chunk of the second operand per stage.
module lsi_mul #(
   parameter int AW = 33,
   parameter int BW = 33
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [AW-1:0] op_a,
   input  logic signed [BW-1:0] op_b,
   output logic signed [AW+BW-1:0] product
);

   localparam int CH = lsi_pkg::MUL_CHUNK;
   localparam int N  = (BW + CH - 1) / CH;
   localparam int PW = AW + BW;
   localparam int XW = N * CH;
   localparam int EW = AW + XW + 1;

   // partial product of a with chunk k of b, placed at its weight
   function automatic logic signed [PW-1:0] term(input logic signed [AW-1:0] a,
                                                 input logic signed [BW-1:0] b,
                                                 input int k);
      logic signed [XW-1:0]   bx;
      logic [CH-1:0]          chunk;
      logic signed [CH:0]     cs;
      logic signed [AW+CH:0]  pr;
      logic signed [EW-1:0]   ex;
      bx    = XW'(b);
      chunk = bx[k*CH +: CH];
      cs    = (k == N-1) ? $signed({chunk[CH-1], chunk}) : $signed({1'b0, chunk});
      pr    = a * cs;
      ex    = EW'(pr);
      ex    = ex <<< (k*CH);
      return $signed(ex[PW-1:0]);
   endfunction

   logic signed [AW-1:0] a_ff   [N];
   logic signed [BW-1:0] b_ff   [N];
   logic signed [PW-1:0] acc_ff [N];

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0]   <= op_a;
         b_ff[0]   <= op_b;
         acc_ff[0] <= term(op_a, op_b, 0);
         for (int k = 1; k < N; k++) begin
            a_ff[k]   <= a_ff[k-1];
            b_ff[k]   <= b_ff[k-1];
            acc_ff[k] <= acc_ff[k-1] + term(a_ff[k-1], b_ff[k-1], k);
         end
      end
   end

   assign product = acc_ff[N-1];

endmodule

// File: rtl/core/lsi_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module lsi_sqrt #(
   parameter int RW = 68
) (
   input  logic            clock,
   input  logic            en,
   input  logic [2*RW-1:0] radicand,
   output logic [RW-1:0]   root
);

   function automatic logic [2*RW+1:0] step(input logic [RW+1:0] rem,
                                            input logic [RW-1:0] rt,
                                            input logic [1:0]    two);
      logic [RW+3:0] cur;
      logic [RW+3:0] trial;
      logic [RW+3:0] diff;
      logic [RW+1:0] rem_n;
      logic [RW-1:0] rt_n;
      cur   = {rem, two};
      trial = {2'b00, rt, 2'b01};
      diff  = cur - trial;
      if (cur >= trial) begin
         rem_n = diff[RW+1:0];
         rt_n  = {rt[RW-2:0], 1'b1};
      end else begin
         rem_n = cur[RW+1:0];
         rt_n  = {rt[RW-2:0], 1'b0};
      end
      return {rem_n, rt_n};
   endfunction

   logic [2*RW-1:0] x_ff   [RW];
   logic [RW+1:0]   rem_ff [RW];
   logic [RW-1:0]   rt_ff  [RW];

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= radicand;
         {rem_ff[0], rt_ff[0]} <= step('0, '0, radicand[2*RW-1 -: 2]);
         for (int k = 1; k < RW; k++) begin
            x_ff[k] <= x_ff[k-1];
            {rem_ff[k], rt_ff[k]} <= step(rem_ff[k-1], rt_ff[k-1],
                                          x_ff[k-1][2*RW-1-2*k -: 2]);
         end
      end
   end

   assign root = rt_ff[RW-1];

endmodule

// File: rtl/core/lsi_div.sv
// Pipelined floor division by a positive divisor, quotient saturated past QB bits.
module lsi_div #(
   parameter int NW   = 103,
   parameter int DENW = 67,
   parameter int QB   = 33
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [NW-1:0] num,
   input  logic [DENW-1:0]      den,
   output logic signed [QB+1:0] quot
);

   localparam int CW = (NW > DENW + QB) ? NW : DENW + QB;

   logic [CW-1:0] rem_ff [QB+1];
   logic [CW-1:0] den_ff [QB+1];
   logic [QB-1:0] q_ff   [QB+1];
   logic          neg_ff [QB+1];
   logic          ovf_ff [QB+1];

   logic [NW-1:0] mag;
   logic [CW-1:0] mag_c;
   logic [CW-1:0] den_top;

   always_comb begin
      mag     = num[NW-1] ? NW'(-num) : NW'(num);
      mag_c   = CW'(mag);
      den_top = CW'(den) << QB;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= mag_c;
         den_ff[0] <= CW'(den);
         q_ff[0]   <= '0;
         neg_ff[0] <= num[NW-1];
         ovf_ff[0] <= (mag_c >= den_top);
         for (int k = 1; k <= QB; k++) begin
            den_ff[k] <= den_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
            if (rem_ff[k-1] >= (den_ff[k-1] << (QB-k))) begin
               rem_ff[k] <= rem_ff[k-1] - (den_ff[k-1] << (QB-k));
               q_ff[k]   <= q_ff[k-1] | (QB'(1) << (QB-k));
            end else begin
               rem_ff[k] <= rem_ff[k-1];
               q_ff[k]   <= q_ff[k-1];
            end
         end
      end
   end

   logic [QB+1:0] qmag;
   logic [QB+1:0] qadj;

   always_comb begin
      qmag = ovf_ff[QB] ? ((QB+2)'(1) << QB) : (QB+2)'(q_ff[QB]);
      qadj = qmag + (QB+2)'(|rem_ff[QB]);
      quot = neg_ff[QB] ? $signed(-qadj) : $signed(qmag);
   end

endmodule

// File: rtl/core/line_sphere_intersection_core.sv
// Top level of the line / sphere intersection core.
//
//   channel | direction | handshake           | word
//   --------+-----------+---------------------+--------------------------------------
//   req     | in        | req_valid/req_stall | start, end, center points, radius
//   rsp     | out       | rsp_valid/rsp_stall | hit count, two points, degenerate flag
//   csr     | in        | csr_wr_en           | tangent epsilon, write only
//
// One word enters per cycle while req_stall is low. The pipe registers the inputs, runs the
// squared-term multipliers, registers a, h and c, runs the h*h and a*c multipliers,
// registers q, runs the bit-per-stage square root, registers the numerators, runs the
// numerator multipliers and the bit-per-stage dividers, then registers the output word.
// Reset is synchronous and clears every valid bit; the epsilon register resets to 1.
// The whole pipe holds while a finished word waits on rsp_stall, so req_stall is
// high exactly when the output register is full and stalled.
module line_sphere_intersection_core #(
   parameter int COORD_WIDTH = lsi_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_start_z,
   input  logic signed [COORD_WIDTH-1:0] req_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_end_z,
   input  logic signed [COORD_WIDTH-1:0] req_center_x,
   input  logic signed [COORD_WIDTH-1:0] req_center_y,
   input  logic signed [COORD_WIDTH-1:0] req_center_z,
   input  logic [COORD_WIDTH-2:0]        req_radius,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_hit_count,
   output logic signed [COORD_WIDTH-1:0] rsp_first_x,
   output logic signed [COORD_WIDTH-1:0] rsp_first_y,
   output logic signed [COORD_WIDTH-1:0] rsp_first_z,
   output logic signed [COORD_WIDTH-1:0] rsp_second_x,
   output logic signed [COORD_WIDTH-1:0] rsp_second_y,
   output logic signed [COORD_WIDTH-1:0] rsp_second_z,
   output logic                          rsp_degenerate,

   input  logic                          csr_wr_en,
   input  logic [lsi_pkg::EPS_WIDTH-1:0] csr_wr_data
);

   // widths: d and f vectors, squared terms, quadratic coefficients, q = disc/4
   localparam int W    = COORD_WIDTH;
   localparam int DW   = W + 1;
   localparam int PW1  = 2 * DW;
   localparam int AW   = PW1 + 2;
   localparam int QW   = 2 * AW + 1;
   localparam int RW   = AW;
   localparam int NMW  = AW + 2;
   localparam int NPW  = NMW + DW;
   localparam int DENW = AW - 1;
   localparam int QB   = W + 1;
   localparam int QOW  = QB + 2;
   localparam int SW   = W + 4;

   localparam int CH = lsi_pkg::MUL_CHUNK;
   localparam int L1 = (DW + CH - 1) / CH;
   localparam int L2 = (AW + CH - 1) / CH;
   localparam int L3 = RW;
   localparam int L5 = QB + 1;

   typedef struct packed {
      logic degen;
      logic miss;
      logic tangent;
   } flags_type;

   localparam int FLW = $bits(flags_type);
   localparam int D1W = 3*W + 3*DW;
   localparam int D2W = 3*W + 3*DW + 2*AW;
   localparam int D3W = D2W + FLW;
   localparam int D4W = 3*W + AW + FLW;
   localparam int D5W = 3*W + FLW;

   // global advance: hold everything while the output word is stalled
   logic rsp_valid_ff;
   logic en;
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // epsilon register
   logic [lsi_pkg::EPS_WIDTH-1:0] eps_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= lsi_pkg::EPS_RESET;
      end else if (csr_wr_en) begin
         eps_ff <= csr_wr_data;
      end
   end

   // ---------------- stage 1: d = E - S, f = S - C ----------------
   logic [2:0][W-1:0] st;
   logic [2:0][W-1:0] en_pt;
   logic [2:0][W-1:0] ct;
   assign st    = {req_start_z,  req_start_y,  req_start_x};
   assign en_pt = {req_end_z,    req_end_y,    req_end_x};
   assign ct    = {req_center_z, req_center_y, req_center_x};

   logic              v1_ff;
   logic [2:0][W-1:0]  s1_ff;
   logic [2:0][DW-1:0] d1_ff;
   logic [2:0][DW-1:0] f1_ff;
   logic [W-2:0]       r1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            s1_ff[k] <= st[k];
            d1_ff[k] <= {en_pt[k][W-1], en_pt[k]} - {st[k][W-1], st[k]};
            f1_ff[k] <= {st[k][W-1], st[k]} - {ct[k][W-1], ct[k]};
         end
         r1_ff <= req_radius;
      end
   end

   // squared terms
   logic signed [PW1-1:0] dd  [3];
   logic signed [PW1-1:0] df  [3];
   logic signed [PW1-1:0] ffp [3];
   logic signed [PW1-1:0] rr;

   for (genvar g = 0; g < 3; g++) begin : g_sq
      lsi_mul #(.AW(DW), .BW(DW)) u_dd (
         .clock(clock), .en(en), .op_a(d1_ff[g]), .op_b(d1_ff[g]), .product(dd[g]));
      lsi_mul #(.AW(DW), .BW(DW)) u_df (
         .clock(clock), .en(en), .op_a(d1_ff[g]), .op_b(f1_ff[g]), .product(df[g]));
      lsi_mul #(.AW(DW), .BW(DW)) u_ff (
         .clock(clock), .en(en), .op_a(f1_ff[g]), .op_b(f1_ff[g]), .product(ffp[g]));
   end

   lsi_mul #(.AW(DW), .BW(DW)) u_rr (
      .clock(clock), .en(en), .op_a({2'b00, r1_ff}), .op_b({2'b00, r1_ff}), .product(rr));

   logic              v1d;
   logic [2:0][W-1:0]  s1d;
   logic [2:0][DW-1:0] d1d;

   lsi_delay #(.WIDTH(D1W), .DEPTH(L1)) u_dly1 (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v1_ff), .in_data({s1_ff, d1_ff}),
      .out_valid(v1d), .out_data({s1d, d1d}));

   // ---------------- stage 2: a, h = b/2, c ----------------
   logic signed [AW-1:0] a_sum;
   logic signed [AW-1:0] h_sum;
   logic signed [AW-1:0] c_sum;

   always_comb begin
      a_sum = AW'(dd[0]) + AW'(dd[1]) + AW'(dd[2]);
      h_sum = AW'(df[0]) + AW'(df[1]) + AW'(df[2]);
      c_sum = AW'(ffp[0]) + AW'(ffp[1]) + AW'(ffp[2]) - AW'(rr);
   end

   logic                 v2_ff;
   logic [2:0][W-1:0]     s2_ff;
   logic [2:0][DW-1:0]    d2_ff;
   logic signed [AW-1:0]  a2_ff;
   logic signed [AW-1:0]  h2_ff;
   logic signed [AW-1:0]  c2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1d;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff <= s1d;
         d2_ff <= d1d;
         a2_ff <= a_sum;
         h2_ff <= h_sum;
         c2_ff <= c_sum;
      end
   end

   logic signed [2*AW-1:0] hh;
   logic signed [2*AW-1:0] ac;

   lsi_mul #(.AW(AW), .BW(AW)) u_hh (
      .clock(clock), .en(en), .op_a(h2_ff), .op_b(h2_ff), .product(hh));
   lsi_mul #(.AW(AW), .BW(AW)) u_ac (
      .clock(clock), .en(en), .op_a(a2_ff), .op_b(c2_ff), .product(ac));

   logic                 v2d;
   logic [2:0][W-1:0]     s2d;
   logic [2:0][DW-1:0]    d2d;
   logic [AW-1:0]         a2d;
   logic [AW-1:0]         h2d;

   lsi_delay #(.WIDTH(D2W), .DEPTH(L2)) u_dly2 (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v2_ff), .in_data({s2_ff, d2_ff, a2_ff, h2_ff}),
      .out_valid(v2d), .out_data({s2d, d2d, a2d, h2d}));

   // ---------------- stage 3: q = h*h - a*c ----------------
   logic                 v3_ff;
   logic [2:0][W-1:0]     s3_ff;
   logic [2:0][DW-1:0]    d3_ff;
   logic [AW-1:0]         a3_ff;
   logic [AW-1:0]         h3_ff;
   logic signed [QW-1:0]  q3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2d;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ff <= s2d;
         d3_ff <= d2d;
         a3_ff <= a2d;
         h3_ff <= h2d;
         q3_ff <= QW'(hh) - QW'(ac);
      end
   end

   // classify here; disc = 4q, so the tangent bound is epsilon / 4
   flags_type fl3;
   always_comb begin
      fl3.degen   = (a3_ff == '0);
      fl3.miss    = q3_ff[QW-1];
      fl3.tangent = !q3_ff[QW-1] && (q3_ff <= $signed(QW'(eps_ff >> 2)));
   end

   logic [RW-1:0] root;

   lsi_sqrt #(.RW(RW)) u_sqrt (
      .clock(clock), .en(en),
      .radicand(fl3.miss ? '0 : q3_ff[2*AW-1:0]),
      .root(root));

   logic                 v3d;
   logic [2:0][W-1:0]     s3d;
   logic [2:0][DW-1:0]    d3d;
   logic [AW-1:0]         a3d;
   logic [AW-1:0]         h3d;
   flags_type             fl3d;

   lsi_delay #(.WIDTH(D3W), .DEPTH(L3)) u_dly3 (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v3_ff), .in_data({s3_ff, d3_ff, a3_ff, h3_ff, fl3}),
      .out_valid(v3d), .out_data({s3d, d3d, a3d, h3d, fl3d}));

   // ---------------- stage 4: numerators -h -/+ R ----------------
   logic signed [NMW-1:0] h_x;
   logic signed [NMW-1:0] r_x;
   always_comb begin
      h_x = NMW'($signed(h3d));
      r_x = NMW'(root);
   end

   logic                  v4_ff;
   logic [2:0][W-1:0]      s4_ff;
   logic [2:0][DW-1:0]     d4_ff;
   logic [AW-1:0]          a4_ff;
   flags_type              fl4_ff;
   logic signed [NMW-1:0]  n1_ff;
   logic signed [NMW-1:0]  n2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3d;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_ff  <= s3d;
         d4_ff  <= d3d;
         a4_ff  <= a3d;
         fl4_ff <= fl3d;
         n1_ff  <= -h_x - r_x;
         n2_ff  <= -h_x + r_x;
      end
   end

   // numerator times direction, then floor divide by a
   logic signed [NPW-1:0] p1 [3];
   logic signed [NPW-1:0] p2 [3];

   for (genvar g = 0; g < 3; g++) begin : g_nd
      lsi_mul #(.AW(NMW), .BW(DW)) u_p1 (
         .clock(clock), .en(en), .op_a(n1_ff), .op_b(d4_ff[g]), .product(p1[g]));
      lsi_mul #(.AW(NMW), .BW(DW)) u_p2 (
         .clock(clock), .en(en), .op_a(n2_ff), .op_b(d4_ff[g]), .product(p2[g]));
   end

   logic                 v4d;
   logic [2:0][W-1:0]     s4d;
   logic [AW-1:0]         a4d;
   flags_type             fl4d;

   lsi_delay #(.WIDTH(D4W), .DEPTH(L1)) u_dly4 (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v4_ff), .in_data({s4_ff, a4_ff, fl4_ff}),
      .out_valid(v4d), .out_data({s4d, a4d, fl4d}));

   logic signed [QOW-1:0] q1 [3];
   logic signed [QOW-1:0] q2 [3];

   for (genvar g = 0; g < 3; g++) begin : g_dv
      lsi_div #(.NW(NPW), .DENW(DENW), .QB(QB)) u_q1 (
         .clock(clock), .en(en), .num(p1[g]), .den(a4d[DENW-1:0]), .quot(q1[g]));
      lsi_div #(.NW(NPW), .DENW(DENW), .QB(QB)) u_q2 (
         .clock(clock), .en(en), .num(p2[g]), .den(a4d[DENW-1:0]), .quot(q2[g]));
   end

   logic                 v5d;
   logic [2:0][W-1:0]     s5d;
   flags_type             fl5d;

   lsi_delay #(.WIDTH(D5W), .DEPTH(L5)) u_dly5 (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v4d), .in_data({s4d, fl4d}),
      .out_valid(v5d), .out_data({s5d, fl5d}));

   // ---------------- stage 5: S + t*d, saturate, output register ----------------
   function automatic logic [W-1:0] sat_sum(input logic [W-1:0] s, input logic [QOW-1:0] q);
      logic signed [SW-1:0] sum;
      logic signed [SW-1:0] hi;
      logic signed [SW-1:0] lo;
      sum = SW'($signed(s)) + SW'($signed(q));
      hi  = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
      lo  = ~hi;
      if (sum > hi) begin
         return hi[W-1:0];
      end else if (sum < lo) begin
         return lo[W-1:0];
      end
      return sum[W-1:0];
   endfunction

   logic [2:0][W-1:0] pt1;
   logic [2:0][W-1:0] pt2;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pt1[k] = sat_sum(s5d[k], q1[k]);
         pt2[k] = sat_sum(s5d[k], q2[k]);
      end
   end

   logic [1:0]        hit_ff;
   logic [2:0][W-1:0] first_ff;
   logic [2:0][W-1:0] second_ff;
   logic              degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v5d;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         degen_ff <= fl5d.degen;
         if (fl5d.degen || fl5d.miss) begin
            hit_ff    <= lsi_pkg::HITS_NONE;
            first_ff  <= '0;
            second_ff <= '0;
         end else if (fl5d.tangent) begin
            hit_ff    <= lsi_pkg::HITS_TANGENT;
            first_ff  <= pt1;
            second_ff <= '0;
         end else begin
            hit_ff    <= lsi_pkg::HITS_CROSS;
            first_ff  <= pt1;
            second_ff <= pt2;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit_count  = hit_ff;
   assign rsp_first_x    = first_ff[0];
   assign rsp_first_y    = first_ff[1];
   assign rsp_first_z    = first_ff[2];
   assign rsp_second_x   = second_ff[0];
   assign rsp_second_y   = second_ff[1];
   assign rsp_second_z   = second_ff[2];
   assign rsp_degenerate = degen_ff;

endmodule

// File: rtl/core/lsi_checker.sv
// Port-level checks for the line / sphere intersection core, with its bind.
`include "assert_macros.svh"

module lsi_checker #(
   parameter int COORD_WIDTH = lsi_pkg::COORD_WIDTH_DEFAULT
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [1:0]             rsp_hit_count,
   input logic [COORD_WIDTH-1:0] rsp_first_x,
   input logic [COORD_WIDTH-1:0] rsp_first_y,
   input logic [COORD_WIDTH-1:0] rsp_first_z,
   input logic [COORD_WIDTH-1:0] rsp_second_x,
   input logic [COORD_WIDTH-1:0] rsp_second_y,
   input logic [COORD_WIDTH-1:0] rsp_second_z,
   input logic                   rsp_degenerate
);

   // stalled result stays valid; its hit count, first x and second z hold
   `LSI_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_hit_count) && $stable(rsp_first_x) && $stable(rsp_second_z), "stalled result changed")

   // input side only stalls behind a stalled output
   `LSI_ASSERT_IMP(a_stall_cause, clock, reset, !rsp_stall, !req_stall, "input stalled without output stall")

   `LSI_ASSERT_IMP(a_degen_nohit, clock, reset, rsp_valid && rsp_degenerate, rsp_hit_count == lsi_pkg::HITS_NONE, "degenerate line reports hits")

   `LSI_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid && rsp_hit_count == lsi_pkg::HITS_NONE, rsp_first_x == '0 && rsp_first_y == '0 && rsp_first_z == '0, "miss with nonzero point")

   `LSI_ASSERT_IMP(a_second_zero, clock, reset, rsp_valid && rsp_hit_count != lsi_pkg::HITS_CROSS, rsp_second_x == '0 && rsp_second_y == '0 && rsp_second_z == '0, "unused second point nonzero")

endmodule

bind line_sphere_intersection_core lsi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lsi_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit_count(rsp_hit_count),
   .rsp_first_x(rsp_first_x), .rsp_first_y(rsp_first_y), .rsp_first_z(rsp_first_z),
   .rsp_second_x(rsp_second_x), .rsp_second_y(rsp_second_y), .rsp_second_z(rsp_second_z),
   .rsp_degenerate(rsp_degenerate));
